/* rtl/bphed_pkg.sv */
// ----------------------------------------------------------------------------
// Button press/hold event detector package
// Shared widths, register defaults, phase and lock-action types.
// ----------------------------------------------------------------------------
package bphed_pkg;

  localparam int KEY_COUNT_DEF = 2;
  localparam int TIME_W        = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_ADDR_W    = 8;
  localparam int FLAG_COUNT    = 4;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_POLL_TIME     = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TIME     = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_JITTER_TIME   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_INACTIVE_TIME = CFG_ADDR_W'(3);

  // Register defaults in milliseconds
  localparam logic [CFG_W-1:0] POLL_TIME_RST     = CFG_W'(50);
  localparam logic [CFG_W-1:0] HOLD_TIME_RST     = CFG_W'(1000);
  localparam logic [CFG_W-1:0] JITTER_TIME_RST   = CFG_W'(50);
  localparam logic [CFG_W-1:0] INACTIVE_TIME_RST = CFG_W'(200);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_POLL = 2'd1,
    PH_LOCK = 2'd2,
    PH_IACT = 2'd3
  } phase_t;

  // Action taken in the lock phase
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_RETIME,
    ACT_HOLD,
    ACT_HOLD_RETIME,
    ACT_UP,
    ACT_HOLD_UP
  } lock_act_t;

  // Indexed by {hold_flag, hold passed, jitter passed, keys differ}
  localparam lock_act_t LOCK_TABLE [16] = '{
    ACT_RETIME,      ACT_NONE,        ACT_RETIME,      ACT_UP,
    ACT_HOLD,        ACT_HOLD_RETIME, ACT_HOLD_RETIME, ACT_HOLD_UP,
    ACT_RETIME,      ACT_HOLD_RETIME, ACT_RETIME,      ACT_HOLD_UP,
    ACT_RETIME,      ACT_NONE,        ACT_RETIME,      ACT_HOLD_UP
  };

endpackage

/* rtl/button_press_hold_event_detector.sv */
// ----------------------------------------------------------------------------
// Button press/hold event detector
// Turns timestamped key polls into DOWN, HOLD, UP and HOLD-release events.
// ----------------------------------------------------------------------------
// Path: from input accept to result valid through the input register, then the
//   result register; the phase machine updates on the same edge as the result.
// Throughput: one item per cycle unless out_tready stalls; one 32-bit subtract
//   and compare per timer in the single combinational pass sets the cycle.
// Reset (rst_n low, synchronous): phase to wait, key and timestamp state to
//   zero, both stages empty, timing registers to their defaults.
module button_press_hold_event_detector
  import bphed_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  localparam int IN_W  = ((TIME_W + KEY_COUNT + 7) / 8) * 8,
  localparam int OUT_W = ((FLAG_COUNT + KEY_COUNT + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Item in: now_ms [31:0], key_levels [32 +: KEY_COUNT], zero padded
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // Result: down_event, hold_event, up_event, hold_up_event, event_keys
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  // Configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  // Timing registers
  logic [CFG_W-1:0] poll_time_r, hold_time_r, jitter_time_r, inactive_time_r;

  // Input stage
  logic                 in_valid_r;
  logic [TIME_W-1:0]    now_r;
  logic [KEY_COUNT-1:0] levels_r;

  // Detector state
  phase_t               phase_r, phase_nxt;
  logic [KEY_COUNT-1:0] key_accum_r, key_accum_nxt;
  logic [KEY_COUNT-1:0] locked_keys_r, locked_keys_nxt;
  logic                 hold_flag_r, hold_flag_nxt;
  logic [TIME_W-1:0]    time_one_r, time_one_nxt;
  logic [TIME_W-1:0]    time_two_r, time_two_nxt;

  // Result stage
  logic                 out_valid_r;
  logic                 down_r, hold_r, up_r, hold_up_r;
  logic                 down_nxt, hold_nxt, up_nxt, hold_up_nxt;
  logic [KEY_COUNT-1:0] event_keys_r, event_keys_nxt;

  // Working values
  logic                 advance;
  logic [KEY_COUNT-1:0] accum;
  logic [TIME_W-1:0]    d1, d2;
  logic [3:0]           lock_code;
  lock_act_t            lock_act;

  // Process the held item when the result register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({event_keys_r, hold_up_r, up_r, hold_r, down_r});

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_time_r     <= POLL_TIME_RST;
      hold_time_r     <= HOLD_TIME_RST;
      jitter_time_r   <= JITTER_TIME_RST;
      inactive_time_r <= INACTIVE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_POLL_TIME:     poll_time_r     <= cfg_data;
        REG_HOLD_TIME:     hold_time_r     <= cfg_data;
        REG_JITTER_TIME:   jitter_time_r   <= cfg_data;
        REG_INACTIVE_TIME: inactive_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r    <= in_tdata[TIME_W-1:0];
      levels_r <= in_tdata[TIME_W +: KEY_COUNT];
    end
  end

  // Phase machine: next state and events for the held poll
  always_comb begin
    phase_nxt       = phase_r;
    key_accum_nxt   = key_accum_r;
    locked_keys_nxt = locked_keys_r;
    hold_flag_nxt   = hold_flag_r;
    time_one_nxt    = time_one_r;
    time_two_nxt    = time_two_r;
    down_nxt        = 1'b0;
    hold_nxt        = 1'b0;
    up_nxt          = 1'b0;
    hold_up_nxt     = 1'b0;
    event_keys_nxt  = '0;

    accum     = key_accum_r | levels_r;
    // Elapsed times wrap modulo 2^32
    d1        = now_r - time_one_r;
    d2        = now_r - time_two_r;
    lock_code = {hold_flag_r, d1 > TIME_W'(hold_time_r), d2 > TIME_W'(jitter_time_r),
                 locked_keys_r != accum};
    lock_act  = LOCK_TABLE[lock_code];

    case (phase_r)
      PH_WAIT: begin
        key_accum_nxt = accum;
        if (accum != '0) begin
          time_one_nxt = now_r;
          phase_nxt    = PH_POLL;
        end
      end
      PH_POLL: begin
        key_accum_nxt = accum;
        // Lock the accumulated keys once the poll window is over.
        if (d1 > TIME_W'(poll_time_r)) begin
          locked_keys_nxt = locked_keys_r | accum;
          key_accum_nxt   = '0;
          phase_nxt       = PH_LOCK;
          time_one_nxt    = now_r;
          time_two_nxt    = now_r;
          down_nxt        = 1'b1;
          event_keys_nxt  = locked_keys_r | accum;
        end
      end
      PH_LOCK: begin
        key_accum_nxt = '0;
        case (lock_act)
          ACT_RETIME: begin
            time_two_nxt = now_r;
          end
          ACT_HOLD, ACT_HOLD_RETIME: begin
            if (lock_act == ACT_HOLD_RETIME) begin
              time_two_nxt = now_r;
            end
            hold_flag_nxt  = 1'b1;
            hold_nxt       = 1'b1;
            event_keys_nxt = locked_keys_r;
          end
          ACT_UP, ACT_HOLD_UP: begin
            up_nxt         = (lock_act == ACT_UP);
            hold_up_nxt    = (lock_act == ACT_HOLD_UP);
            event_keys_nxt = locked_keys_r;
            phase_nxt      = PH_IACT;
            time_one_nxt   = now_r;
          end
          default: ;
        endcase
      end
      PH_IACT: begin
        // Lockout: drop all key state until the inactive time has gone by.
        key_accum_nxt   = '0;
        locked_keys_nxt = '0;
        hold_flag_nxt   = 1'b0;
        if (d1 > TIME_W'(inactive_time_r)) begin
          phase_nxt = PH_WAIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WAIT;
      key_accum_r   <= '0;
      locked_keys_r <= '0;
      hold_flag_r   <= 1'b0;
      time_one_r    <= '0;
      time_two_r    <= '0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      key_accum_r   <= key_accum_nxt;
      locked_keys_r <= locked_keys_nxt;
      hold_flag_r   <= hold_flag_nxt;
      time_one_r    <= time_one_nxt;
      time_two_r    <= time_two_nxt;
    end
  end

  // Result register: load on advance, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      down_r       <= down_nxt;
      hold_r       <= hold_nxt;
      up_r         <= up_nxt;
      hold_up_r    <= hold_up_nxt;
      event_keys_r <= event_keys_nxt;
    end
  end

  // At most one event per result.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({down_r, hold_r, up_r, hold_up_r}))
    else $error("more than one event in a result");

  // Key mask travels only with an event.
  a_keys_need_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !(down_r || hold_r || up_r || hold_up_r)) |-> (event_keys_r == '0))
    else $error("event keys set without an event");

  // Before a lock there is no locked set and no hold.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT || phase_r == PH_POLL) |-> (locked_keys_r == '0 && !hold_flag_r))
    else $error("locked state left over outside lock");

  // A DOWN result is produced together with entry into lock.
  a_down_locks: assert property (@(posedge clk) disable iff (!rst_n)
    advance && down_nxt |=> (phase_r == PH_LOCK && down_r))
    else $error("down event without lock entry");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press/hold event detector testbench
// Drives timestamped key polls through the block, keeps a cycle-free model of
// the press/hold/release machine alongside it, and checks every result item
// field by field while both stream sides idle and stall at random. Timing
// registers are changed between phases, including all-zero and all-ones.
// ----------------------------------------------------------------------------
module tb;
  import bphed_pkg::*;

  localparam int IN_W  = ((TIME_W + KEY_COUNT_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((FLAG_COUNT + KEY_COUNT_DEF + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  // Indexes past the last timing register; writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_PAST_END = REG_INACTIVE_TIME + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP      = {CFG_ADDR_W{1'b1}};

  typedef struct {
    logic       down;
    logic       hold;
    logic       up;
    logic       hold_up;
    logic [1:0] keys;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;   // now_ms [31:0], key_levels [33:32]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // down, hold, up, hold_up, event_keys [5:4]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  button_press_hold_event_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the timing registers, at their reset values
  logic [CFG_W-1:0] poll_ms     = POLL_TIME_RST;
  logic [CFG_W-1:0] hold_ms     = HOLD_TIME_RST;
  logic [CFG_W-1:0] jitter_ms   = JITTER_TIME_RST;
  logic [CFG_W-1:0] inactive_ms = INACTIVE_TIME_RST;

  // Shadow of the detector state
  phase_t      ph          = PH_WAIT;
  logic [1:0]  accum_keys  = '0;
  logic [1:0]  locked_keys = '0;
  logic        held        = 1'b0;
  logic [31:0] press_ms    = '0;   // press / lock / release timestamp
  logic [31:0] jitter_ref  = '0;   // jitter timestamp

  key_event_t  pending_events[$];
  key_event_t  want_ev, seen_ev;

  int          mismatches = 0;
  int          polls_sent = 0;
  int          results_seen = 0;
  int          n_down = 0, n_hold = 0, n_up = 0, n_hold_up = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          valid_up = 1'b0;
  logic [31:0] last_now = '0;

  // Advance the shadow machine by one poll and return the event it gives.
  function automatic key_event_t detect_events(input logic [31:0] now,
                                               input logic [1:0] lv);
    key_event_t  ev;
    logic [31:0] since_press, since_jitter;
    logic        hold_passed, jitter_passed, differ;
    ev           = '{default: '0};
    since_press  = now - press_ms;
    since_jitter = now - jitter_ref;
    accum_keys   = accum_keys | lv;
    case (ph)
      PH_WAIT: begin
        if (accum_keys != 2'b00) begin
          press_ms = now;
          ph       = PH_POLL;
        end
      end
      PH_POLL: begin
        if (since_press > poll_ms) begin
          locked_keys = locked_keys | accum_keys;
          accum_keys  = '0;
          ph          = PH_LOCK;
          press_ms    = now;
          jitter_ref  = now;
          ev.down     = 1'b1;
          ev.keys     = locked_keys;
        end
      end
      PH_LOCK: begin
        hold_passed   = since_press > hold_ms;
        jitter_passed = since_jitter > jitter_ms;
        differ        = locked_keys != accum_keys;
        if (jitter_passed && differ) begin
          // Release: a plain UP only when no hold was given and none is due
          if (held || hold_passed) ev.hold_up = 1'b1;
          else ev.up = 1'b1;
          ev.keys  = locked_keys;
          ph       = PH_IACT;
          press_ms = now;
        end else if ((!held && hold_passed) || (held && !hold_passed && differ)) begin
          // First hold, or the repeated hold after the timer wraps back
          if (jitter_passed || differ) jitter_ref = now;
          held    = 1'b1;
          ev.hold = 1'b1;
          ev.keys = locked_keys;
        end else if (!differ) begin
          jitter_ref = now;
        end
        accum_keys = '0;
      end
      default: begin
        accum_keys  = '0;
        locked_keys = '0;
        held        = 1'b0;
        if (since_press > inactive_ms) ph = PH_WAIT;
      end
    endcase
    return ev;
  endfunction

  // Send one poll item, predict its event, then maybe drop valid for a gap.
  task automatic send_item(input logic [31:0] now, input logic [1:0] keys);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({keys, now});
    valid_up   = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_events.push_back(detect_events(now, keys));
    last_now = now;
    polls_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // Mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom % 4 == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        valid_up   = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every predicted event has come out.
  task automatic wait_idle();
    if (valid_up) begin
      in_tvalid <= 1'b0;
      valid_up   = 1'b0;
    end
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four timing registers, then one stray index that must be dropped.
  task automatic set_timing(input logic [CFG_W-1:0] p, h, j, ia);
    logic [CFG_ADDR_W-1:0] idx [5];
    logic [CFG_W-1:0]      val [5];
    idx = '{REG_POLL_TIME, REG_HOLD_TIME, REG_JITTER_TIME, REG_INACTIVE_TIME,
            CFG_ADDR_W'($urandom_range(REG_PAST_END, REG_TOP))};
    val = '{p, h, j, ia, CFG_W'($urandom)};
    wait_idle();
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_POLL_TIME:     poll_ms     = val[k];
        REG_HOLD_TIME:     hold_ms     = val[k];
        REG_JITTER_TIME:   jitter_ms   = val[k];
        REG_INACTIVE_TIME: inactive_ms = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Pick a timestamp: right on a threshold, one past it, or a step from the
  // last poll. Stepping from an anchor may move time backward, which is legal.
  function automatic logic [31:0] pick_time(input logic [31:0] anchor,
                                            input logic [CFG_W-1:0] thr);
    int unsigned span;
    span = 32'(thr);
    case ($urandom % 10)
      0, 1:       return anchor + span;
      2, 3:       return anchor + span + 1;
      4, 5, 6, 7: return last_now + $urandom_range(0, span / 4 + 1);
      8:          return last_now + $urandom_range(0, 2 * span + 2);
      default:    return last_now;
    endcase
  endfunction

  // Random polls steered by the shadow phase so that presses run through.
  task automatic run_polls(input int count);
    logic [31:0] now;
    logic [1:0]  keys;
    repeat (count) begin
      if ($urandom % 100 < 4) begin
        // Noise: any time, any keys
        now  = $urandom;
        keys = 2'($urandom_range(0, 3));
      end else begin
        case (ph)
          PH_WAIT: begin
            now  = last_now + $urandom_range(0, 40);
            keys = ($urandom % 4 == 0) ? 2'b00 : 2'($urandom_range(1, 3));
          end
          PH_POLL: begin
            now  = pick_time(press_ms, poll_ms);
            keys = 2'($urandom_range(0, 3));
          end
          PH_LOCK: begin
            now  = ($urandom % 2) ? pick_time(press_ms, hold_ms)
                                  : pick_time(jitter_ref, jitter_ms);
            keys = ($urandom % 100 < 55) ? locked_keys : 2'($urandom_range(0, 3));
          end
          default: begin
            now  = pick_time(press_ms, inactive_ms);
            keys = 2'($urandom_range(0, 3));
          end
        endcase
      end
      send_item(now, keys);
    end
  endtask

  // Directed presses under the reset timing: quick tap, hold with a repeated
  // hold after time steps back, release right at hold time, and a press that
  // spans the 32-bit wrap of the millisecond counter.
  task automatic test_directed();
    logic [31:0] t [25];
    logic [1:0]  k [25];
    t = '{32'd1000, 32'd1010, 32'd1030, 32'd1060, 32'd1061, 32'd1100, 32'd1200,
          32'd1300, 32'd1401,
          32'd1500, 32'd1551, 32'd2551, 32'd2552, 32'd2051, 32'd2061, 32'd2070,
          32'd3000,
          32'd3201, 32'd5000, 32'd5051, 32'd6052,
          32'hFFFF_FFF0, 32'h0000_0023, 32'hFFFF_FFFF, 32'h0000_0000};
    k = '{2'b00, 2'b01, 2'b10, 2'b00, 2'b00, 2'b11, 2'b01,
          2'b11, 2'b00,
          2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b00, 2'b00,
          2'b00,
          2'b00, 2'b10, 2'b10, 2'b00,
          2'b11, 2'b00, 2'b11, 2'b00};
    for (int i = 0; i < 25; i++) send_item(t[i], k[i]);
  endtask

  task automatic test_random_defaults();
    run_polls(150);
  endtask

  // Zero thresholds make every comparison pass once any time goes by; all-ones
  // ones need long jumps in time; then a mix of the two.
  task automatic test_threshold_extremes();
    set_timing('0, '0, '0, '0);
    run_polls(80);
    set_timing('1, '1, '1, '1);
    run_polls(80);
    set_timing('0, '1, '0, '1);
    run_polls(40);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      set_timing(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 1500)),
                 CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 65535)));
      run_polls(80);
    end
  endtask

  // Receiver: rotate through always ready, random stalls, a fixed pattern
  // and long stalls so back-pressure hits every stage.
  always @(posedge clk) begin
    case ((cycles / 97) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom % 10) < 7;
      2:       out_tready <= (cycles % 8) >= 3;
      default: out_tready <= (cycles % 32) >= 12;
    endcase
  end

  function automatic void check_field(input string what, input logic [1:0] want,
                                      input logic [1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest pending event.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_ev.down    = out_tdata[0];
      seen_ev.hold    = out_tdata[1];
      seen_ev.up      = out_tdata[2];
      seen_ev.hold_up = out_tdata[3];
      seen_ev.keys    = out_tdata[5:4];
      results_seen++;
      n_down    += seen_ev.down;
      n_hold    += seen_ev.hold;
      n_up      += seen_ev.up;
      n_hold_up += seen_ev.hold_up;
      if (pending_events.size() == 0) begin
        $display("%0t: result item %h with no poll outstanding", $time, out_tdata);
        mismatches++;
      end else begin
        want_ev = pending_events.pop_front();
        check_field("down_event", 2'(want_ev.down), 2'(seen_ev.down));
        check_field("hold_event", 2'(want_ev.hold), 2'(seen_ev.hold));
        check_field("up_event", 2'(want_ev.up), 2'(seen_ev.up));
        check_field("hold_up_event", 2'(want_ev.hold_up), 2'(seen_ev.hold_up));
        check_field("event_keys", want_ev.keys, seen_ev.keys);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycles,
               pending_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_defaults();
    test_threshold_extremes();
    test_random_settings();
    // Drain, then let the pipeline settle before the verdict
    wait_idle();
    repeat (10) @(posedge clk);
    $display("ran %0d polls, checked %0d results under reset, extreme and random timing",
             polls_sent, results_seen);
    $display("events seen: down %0d, hold %0d, up %0d, hold-release %0d",
             n_down, n_hold, n_up, n_hold_up);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
